>>> sv/rsplit_pkg.sv
// shared types and constants for the read interval splitter
package rsplit_pkg;

  // default position width and job queue depth
  localparam int POS_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH   = 4;

  // input command codes
  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_ADAPTER = 2'd1,
    CMD_FINISH  = 2'd2
  } cmd_t;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_WINDOW  = 2'd0,
    KIND_SUBREAD = 2'd1,
    KIND_ADAPTER = 2'd2
  } kind_t;

  // handshake between the queue and its neighbors
  typedef struct packed {
    logic push;
    logic pop;
  } q_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> sv/rsplit_front.sv
// front part: holds the read window state and turns each input item into a job
module rsplit_front
  import rsplit_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  localparam int RES_W    = 2 * POS_WIDTH + 5,
  localparam int JOB_W    = 2 * RES_W + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,        // input transfer this cycle
  input  logic [1:0]           cmd,
  input  logic [POS_WIDTH-1:0] pos_a,
  input  logic [POS_WIDTH-1:0] pos_b,
  input  logic [POS_WIDTH-1:0] read_length,
  input  logic                 has_window,
  output logic                 job_valid,  // job to push for this item
  output logic [JOB_W-1:0]     job_data    // {two results, result 1, result 0}
);

  logic [POS_WIDTH-1:0] win_start_r, win_start_nxt;
  logic [POS_WIDTH-1:0] win_end_r, win_end_nxt;
  logic [POS_WIDTH-1:0] next_sub_r, next_sub_nxt;
  logic                 seen_r, seen_nxt;
  logic                 win_valid_r, win_valid_nxt;
  logic                 scan_done_r, scan_done_nxt;

  logic [POS_WIDTH-1:0] end_fix;
  logic [POS_WIDTH-1:0] clip_s;
  logic [POS_WIDTH-1:0] clip_e;
  logic [POS_WIDTH-1:0] cs_tmp;
  logic [RES_W-1:0]     res0;
  logic [RES_W-1:0]     res1;
  logic                 two;

  // repaired end bound and clipped adapter bounds
  always_comb begin
    end_fix = pos_b;
    if ((read_length != '0) && (pos_b == read_length - POS_WIDTH'(1))) begin
      end_fix = read_length;
    end
    cs_tmp = (win_start_r > pos_a) ? win_start_r : pos_a;
    clip_s = (next_sub_r > cs_tmp) ? next_sub_r : cs_tmp;
    clip_e = (pos_b < win_end_r) ? pos_b : win_end_r;
  end

  // classify the item, build its job and the next state
  always_comb begin
    win_start_nxt = win_start_r;
    win_end_nxt   = win_end_r;
    next_sub_nxt  = next_sub_r;
    seen_nxt      = seen_r;
    win_valid_nxt = win_valid_r;
    scan_done_nxt = scan_done_r;
    job_valid     = 1'b0;
    two           = 1'b0;
    res0          = '0;
    res1          = '0;
    case (cmd)
      CMD_BEGIN: begin
        seen_nxt      = 1'b0;
        scan_done_nxt = 1'b0;
        job_valid     = 1'b1;
        if (!has_window || (end_fix <= pos_a)) begin
          win_valid_nxt = 1'b0;
          win_start_nxt = '0;
          win_end_nxt   = '0;
          next_sub_nxt  = '0;
          res0 = {1'b1, 1'b0, 1'b0, {POS_WIDTH{1'b0}}, {POS_WIDTH{1'b0}}, KIND_WINDOW};
        end else begin
          win_valid_nxt = 1'b1;
          win_start_nxt = pos_a;
          win_end_nxt   = end_fix;
          next_sub_nxt  = pos_a;
          res0 = {1'b1, 1'b0, 1'b0, end_fix, pos_a, KIND_WINDOW};
        end
      end
      CMD_ADAPTER: begin
        if (win_valid_r && !scan_done_r && !(win_start_r > pos_b)) begin
          if (win_end_r < pos_a) begin
            scan_done_nxt = 1'b1;
          end else begin
            job_valid    = 1'b1;
            two          = next_sub_r < pos_a;
            res1         = {1'b1, 1'b0, 1'b0, clip_e, clip_s, KIND_ADAPTER};
            res0         = two ? {1'b0, 1'b1, seen_r, pos_a, next_sub_r, KIND_SUBREAD}
                               : res1;
            next_sub_nxt = pos_b;
            seen_nxt     = 1'b1;
          end
        end
      end
      CMD_FINISH: begin
        win_valid_nxt = 1'b0;
        if (win_valid_r && (next_sub_r < win_end_r)) begin
          job_valid = 1'b1;
          res0 = {1'b1, 1'b0, seen_r, win_end_r, next_sub_r, KIND_SUBREAD};
        end
      end
      default: begin
      end
    endcase
    job_data = {two, res1, res0};
  end

  // state registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_end_r   <= '0;
      next_sub_r  <= '0;
      seen_r      <= 1'b0;
      win_valid_r <= 1'b0;
      scan_done_r <= 1'b0;
    end else if (acc) begin
      win_start_r <= win_start_nxt;
      win_end_r   <= win_end_nxt;
      next_sub_r  <= next_sub_nxt;
      seen_r      <= seen_nxt;
      win_valid_r <= win_valid_nxt;
      scan_done_r <= scan_done_nxt;
    end
  end

endmodule

>>> sv/rsplit_fifo.sv
// short job queue between the front and back parts
module rsplit_fifo
  import rsplit_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_req_t           req,
  input  logic [WIDTH-1:0] wr_data,
  output q_stat_t          stat,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = req.push && !stat.full;
  assign do_pop     = req.pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  // pointer and count update with wraparound
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> sv/rsplit_back.sv
// back part: plays each queued job out as one or two result transfers
module rsplit_back
  import rsplit_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  localparam int RES_W    = 2 * POS_WIDTH + 5,
  localparam int JOB_W    = 2 * RES_W + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_avail,
  input  logic [JOB_W-1:0]     job_data,
  output logic                 job_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [POS_WIDTH-1:0] start_pos,
  output logic [POS_WIDTH-1:0] end_pos,
  output logic                 pre_adapt,
  output logic                 post_adapt,
  output logic                 last
);

  logic             beat_r, beat_nxt;
  logic             two;
  logic [RES_W-1:0] cur;
  logic             xfer;

  assign two       = job_data[JOB_W-1];
  assign cur       = beat_r ? job_data[2*RES_W-1:RES_W] : job_data[RES_W-1:0];
  assign out_valid = job_avail;
  assign xfer      = out_valid && out_ready;
  assign job_pop   = xfer && (!two || beat_r);

  // unpack the current result
  assign kind       = cur[1:0];
  assign start_pos  = cur[POS_WIDTH+1:2];
  assign end_pos    = cur[2*POS_WIDTH+1:POS_WIDTH+2];
  assign pre_adapt  = cur[2*POS_WIDTH+2];
  assign post_adapt = cur[2*POS_WIDTH+3];
  assign last       = cur[2*POS_WIDTH+4];

  // second beat of a two-result job
  always_comb begin
    beat_nxt = beat_r;
    if (xfer) begin
      beat_nxt = two && !beat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

endmodule

>>> sv/read_interval_splitter_top.sv
// top level of the read interval splitter
// Takes one input transfer per cycle whenever the 4-entry job queue has room.
// A begin item yields one window result, an adapter item zero, one or two
// results (a subread then the clipped adapter), a finish item zero or one
// trailing subread. The result port delivers one result per cycle while out_tready
// is high, so an adapter item with a leading subread holds the result side for two
// results; the queue between the classifier and the output sequencer absorbs this.
// Each job is registered in the job queue before its results reach the result port.
module read_interval_splitter_top
  import rsplit_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  localparam int IN_W     = ((3 * POS_WIDTH + 1 + 7) / 8) * 8,
  localparam int OUT_W    = ((2 * POS_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // pos_a, pos_b, read_length, has_window
  input  logic [1:0]       in_tuser,   // cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // start_pos, end_pos, pre_adapt, post_adapt
  output logic [1:0]       out_tuser,  // kind
  output logic             out_tlast
);

  localparam int RES_W = 2 * POS_WIDTH + 5;
  localparam int JOB_W = 2 * RES_W + 1;

  logic                 acc;
  logic                 job_valid;
  logic [JOB_W-1:0]     job_in;
  logic [JOB_W-1:0]     job_out;
  q_req_t               q_req;
  q_stat_t              q_stat;
  logic                 job_pop;
  logic [POS_WIDTH-1:0] start_pos;
  logic [POS_WIDTH-1:0] end_pos;
  logic                 pre_adapt;
  logic                 post_adapt;

  assign in_tready  = !q_stat.full;
  assign acc        = in_tvalid && in_tready;
  assign q_req.push = acc && job_valid;
  assign q_req.pop  = job_pop;

  // item classification and window state
  rsplit_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .cmd         (in_tuser),
    .pos_a       (in_tdata[POS_WIDTH-1:0]),
    .pos_b       (in_tdata[2*POS_WIDTH-1:POS_WIDTH]),
    .read_length (in_tdata[3*POS_WIDTH-1:2*POS_WIDTH]),
    .has_window  (in_tdata[3*POS_WIDTH]),
    .job_valid   (job_valid),
    .job_data    (job_in)
  );

  // job queue
  rsplit_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (q_req),
    .wr_data (job_in),
    .stat    (q_stat),
    .rd_data (job_out)
  );

  // result sequencing
  rsplit_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_avail  (!q_stat.empty),
    .job_data   (job_out),
    .job_pop    (job_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .kind       (out_tuser),
    .start_pos  (start_pos),
    .end_pos    (end_pos),
    .pre_adapt  (pre_adapt),
    .post_adapt (post_adapt),
    .last       (out_tlast)
  );

  // pack result payload, zero fill to whole bytes
  assign out_tdata = OUT_W'({post_adapt, pre_adapt, end_pos, start_pos});

endmodule
